[rtl/tns_pkg.sv]
`default_nettype none
package tns_pkg;

  localparam int SONG_COUNT = 4;
  localparam int MAX_NOTES  = 64;

  localparam int SONG_W  = 2;
  localparam int NOTE_W  = 6;
  localparam int FREQ_W  = 16;
  localparam int DUR_W   = 16;
  localparam int LEN_W   = 7;
  localparam int BASE_W  = 24;
  localparam int DIV_W   = 16;
  localparam int SPK_W   = 2;
  localparam int FUNC_W  = 3;

  localparam int NOTE_DEPTH   = SONG_COUNT * MAX_NOTES;
  localparam int NOTE_ADDR_W  = $clog2(NOTE_DEPTH);
  localparam int ENTRY_W      = FREQ_W + DUR_W;
  localparam int DIV_CNT_W    = $clog2(BASE_W + 1);

  localparam int IN_TDATA_W   = 48;
  localparam int OUT_TDATA_W  = 24;
  localparam int CFG_DATA_W   = 32;
  localparam int CFG_ADDR_W   = 3;

  localparam logic [BASE_W-1:0] BASE_RESET = BASE_W'(1193182);

  localparam logic [SPK_W-1:0] SPK_BOTH = 2'b11;
  localparam logic [SPK_W-1:0] SPK_DATA = 2'b10;

  localparam logic [FUNC_W-1:0] FUNC_TICK  = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_NEXT  = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_PREV  = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_MUTE  = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_WNOTE = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_WLEN  = 3'd5;

  localparam logic CFG_IDX_BASE = 1'b0;

  typedef enum logic [2:0] {
    OP_TICK,
    OP_NEXT,
    OP_PREV,
    OP_MUTE,
    OP_WNOTE,
    OP_WLEN,
    OP_NOP
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_DIVIDE
  } state_t;

  typedef struct packed {
    op_t               op;
    logic [SONG_W-1:0] song_sel;
    logic [NOTE_W-1:0] note_sel;
    logic [FREQ_W-1:0] freq;
    logic [DUR_W-1:0]  dur;
    logic [LEN_W-1:0]  slen;
  } cmd_t;

  typedef struct packed {
    logic              tone_load;
    logic [DIV_W-1:0]  divisor;
    logic [SPK_W-1:0]  spk;
    logic [SONG_W-1:0] song;
    logic              muted;
  } result_t;

endpackage
`default_nettype wire

[rtl/tone_note_sequencer.sv]
// Channel  Direction  Contents
// in_      input      tuser: func; tdata: song_sel, note_sel, note_frequency,
//                     note_duration, song_length
// out_     output     tuser: tone_load; tdata: tone_divisor, speaker_bits,
//                     current_song_out, muted
// cfg_     input      base_clock_hz at byte address 0
//
// A transaction that needs no table lookup goes from acceptance straight to the result register.
// A tick that fetches a note reads it in ST_FETCH; a rest, or a note when muted, then sets
// the result; a sounding note waits in ST_DIVIDE on the one-bit-per-cycle divider.
// Reset is synchronous and active low; the note and length tables are not cleared.
// Items are taken one at a time by the sequencer; a two-entry queue in front
// keeps accepting, until full, while the result register waits for out_tready.
`default_nettype none
module tone_note_sequencer
  import tns_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // song_sel[1:0], note_sel[7:2], note_frequency[23:8], note_duration[39:24],
  // song_length[46:40], zero[47]
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // func[2:0]
  input  wire logic [FUNC_W-1:0]      in_tuser,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // tone_divisor[15:0], speaker_bits[17:16], current_song_out[19:18],
  // muted[20], zero[23:21]
  output logic      [OUT_TDATA_W-1:0] out_tdata,
  // tone_load[0]
  output logic                        out_tuser,
  input  wire logic                   cfg_psel,
  input  wire logic                   cfg_penable,
  input  wire logic                   cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0]  cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0]  cfg_pwdata,
  output logic      [CFG_DATA_W-1:0]  cfg_prdata,
  output logic                        cfg_pready
);

  logic [BASE_W-1:0] base_r, base_nxt;
  logic              cfg_wr;
  logic              cmd_valid;
  logic              cmd_ready;
  cmd_t              cmd;
  result_t           res;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                      && (cfg_paddr[2] == CFG_IDX_BASE);
  assign base_nxt   = cfg_wr ? cfg_pwdata[BASE_W-1:0] : base_r;
  assign cfg_prdata = (cfg_paddr[2] == CFG_IDX_BASE) ? CFG_DATA_W'(base_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= BASE_RESET;
    end else begin
      base_r <= base_nxt;
    end
  end

  tns_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  tns_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_valid     (cmd_valid),
    .cmd_ready     (cmd_ready),
    .cmd           (cmd),
    .base_clock_hz (base_r),
    .res_valid     (out_tvalid),
    .res_ready     (out_tready),
    .res           (res)
  );

  assign out_tdata = {3'b000, res.muted, res.song, res.spk, res.divisor};
  assign out_tuser = res.tone_load;

endmodule
`default_nettype wire

[rtl/tns_ram.sv]
`default_nettype none
module tns_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule
`default_nettype wire

[rtl/tns_front.sv]
`default_nettype none
module tns_front
  import tns_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_TDATA_W-1:0] in_tdata,
  input  wire logic [FUNC_W-1:0]     in_tuser,
  output logic                       cmd_valid,
  input  wire logic                  cmd_ready,
  output cmd_t                       cmd
);

  cmd_t       q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  cmd_t       cmd_in;
  logic       push, pop;

  always_comb begin
    cmd_in.song_sel = in_tdata[1:0];
    cmd_in.note_sel = in_tdata[7:2];
    cmd_in.freq     = in_tdata[23:8];
    cmd_in.dur      = in_tdata[39:24];
    cmd_in.slen     = in_tdata[46:40];
    unique case (in_tuser)
      FUNC_TICK:  cmd_in.op = OP_TICK;
      FUNC_NEXT:  cmd_in.op = OP_NEXT;
      FUNC_PREV:  cmd_in.op = OP_PREV;
      FUNC_MUTE:  cmd_in.op = OP_MUTE;
      FUNC_WNOTE: cmd_in.op = OP_WNOTE;
      FUNC_WLEN:  cmd_in.op = OP_WLEN;
      default:    cmd_in.op = OP_NOP;
    endcase
  end

  assign in_tready = (cnt_r != 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rd_ptr_r];
  assign push      = in_tvalid && in_tready;
  assign pop       = cmd_valid && cmd_ready;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule
`default_nettype wire

[rtl/tns_div.sv]
`default_nettype none
module tns_div
  import tns_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [BASE_W-1:0] dividend,
  input  wire logic [FREQ_W-1:0] divisor,
  output logic                   done,
  output logic      [DIV_W-1:0]  quotient
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [BASE_W-1:0]    quo_r, quo_nxt;
  logic [FREQ_W:0]      rem_r, rem_nxt;
  logic [FREQ_W-1:0]    dvsr_r, dvsr_nxt;
  logic [FREQ_W:0]      rem_sh;
  logic                 ge;

  always_comb begin
    rem_sh   = {rem_r[FREQ_W-1:0], quo_r[BASE_W-1]};
    ge       = (rem_sh >= {1'b0, dvsr_r});
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvsr_nxt = dvsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_W'(BASE_W);
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvsr_nxt = divisor;
    end else if (busy_r) begin
      quo_nxt = {quo_r[BASE_W-2:0], ge};
      rem_nxt = ge ? (rem_sh - {1'b0, dvsr_r}) : rem_sh;
      cnt_nxt = cnt_r - DIV_CNT_W'(1);
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    dvsr_r <= dvsr_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r[DIV_W-1:0];

endmodule
`default_nettype wire

[rtl/tns_back.sv]
`default_nettype none
module tns_back
  import tns_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cmd_valid,
  output logic                   cmd_ready,
  input  wire cmd_t              cmd,
  input  wire logic [BASE_W-1:0] base_clock_hz,
  output logic                   res_valid,
  input  wire logic              res_ready,
  output result_t                res
);

  state_t            state_r, state_nxt;
  logic [SONG_W-1:0] song_r, song_nxt;
  logic [NOTE_W-1:0] note_r, note_nxt;
  logic [DUR_W-1:0]  cnt_r, cnt_nxt;
  logic              mute_r, mute_nxt;
  logic [SPK_W-1:0]  spk_r, spk_nxt;
  logic [DIV_W-1:0]  div_r, div_nxt;
  logic              load_r, load_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [LEN_W-1:0]  len_r [SONG_COUNT];

  logic              accept;
  logic              fetch;
  logic              res_set;
  logic              div_start;
  logic              div_done;
  logic [DIV_W-1:0]  div_q;
  logic [ENTRY_W-1:0] entry;
  logic [FREQ_W-1:0] entry_freq;
  logic [DUR_W-1:0]  entry_dur;
  logic [NOTE_W:0]   note_inc;
  logic              note_wrap;
  logic              rest;

  assign cmd_ready  = (state_r == ST_IDLE) && !out_valid_r;
  assign accept     = cmd_valid && cmd_ready;
  assign fetch      = accept && (cmd.op == OP_TICK) && (cnt_r == '0);
  assign entry_freq = entry[FREQ_W-1:0];
  assign entry_dur  = entry[ENTRY_W-1:FREQ_W];
  assign rest       = (entry_freq == '0) || mute_r;
  assign note_inc   = {1'b0, note_r} + (NOTE_W+1)'(1);
  assign note_wrap  = (note_inc >= len_r[song_r]) || (note_inc >= (NOTE_W+1)'(MAX_NOTES));

  tns_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NOTE_DEPTH)
  ) u_note_ram (
    .clk     (clk),
    .wr_en   (accept && (cmd.op == OP_WNOTE)),
    .wr_addr ({cmd.song_sel, cmd.note_sel}),
    .wr_data ({cmd.dur, cmd.freq}),
    .rd_en   (fetch),
    .rd_addr ({song_r, note_r}),
    .rd_data (entry)
  );

  tns_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (base_clock_hz),
    .divisor  (entry_freq),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (fetch) begin
          state_nxt = ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_nxt = rest ? ST_IDLE : ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (div_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    song_nxt  = song_r;
    note_nxt  = note_r;
    cnt_nxt   = cnt_r;
    mute_nxt  = mute_r;
    spk_nxt   = spk_r;
    div_nxt   = div_r;
    load_nxt  = load_r;
    res_set   = 1'b0;
    div_start = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          load_nxt = 1'b0;
          res_set  = !fetch;
          unique case (cmd.op)
            OP_TICK: begin
              if (cnt_r != '0) begin
                cnt_nxt = cnt_r - DUR_W'(1);
              end
            end
            OP_NEXT: begin
              song_nxt = (song_r == SONG_W'(SONG_COUNT - 1)) ? '0 : song_r + SONG_W'(1);
              note_nxt = '0;
              cnt_nxt  = '0;
              spk_nxt  = spk_r & ~SPK_DATA;
            end
            OP_PREV: begin
              song_nxt = (song_r == '0) ? SONG_W'(SONG_COUNT - 1) : song_r - SONG_W'(1);
              note_nxt = '0;
              cnt_nxt  = '0;
              spk_nxt  = spk_r & ~SPK_DATA;
            end
            OP_MUTE: begin
              mute_nxt = !mute_r;
              if (!mute_r) begin
                spk_nxt = spk_r & ~SPK_DATA;
              end
            end
            OP_WNOTE, OP_WLEN, OP_NOP: begin
            end
            default: begin
            end
          endcase
        end
      end
      ST_FETCH: begin
        cnt_nxt  = entry_dur;
        note_nxt = note_wrap ? '0 : note_inc[NOTE_W-1:0];
        if (rest) begin
          spk_nxt = spk_r & ~SPK_BOTH;
          res_set = 1'b1;
        end else begin
          div_start = 1'b1;
        end
      end
      ST_DIVIDE: begin
        if (div_done) begin
          div_nxt  = div_q;
          spk_nxt  = spk_r | SPK_BOTH;
          load_nxt = 1'b1;
          res_set  = 1'b1;
        end
      end
      default: begin
      end
    endcase
    out_valid_nxt = res_set || (out_valid_r && !res_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      song_r      <= '0;
      note_r      <= '0;
      cnt_r       <= '0;
      mute_r      <= 1'b0;
      spk_r       <= '0;
      div_r       <= '0;
      load_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      song_r      <= song_nxt;
      note_r      <= note_nxt;
      cnt_r       <= cnt_nxt;
      mute_r      <= mute_nxt;
      spk_r       <= spk_nxt;
      div_r       <= div_nxt;
      load_r      <= load_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (cmd.op == OP_WLEN)) begin
      len_r[cmd.song_sel] <= cmd.slen;
    end
  end

  assign res_valid     = out_valid_r;
  assign res.tone_load = load_r;
  assign res.divisor   = div_r;
  assign res.spk       = spk_r;
  assign res.song      = song_r;
  assign res.muted     = mute_r;

endmodule
`default_nettype wire

[rtl/tns_checker.sv]
`default_nettype none
module tns_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [23:0] out_tdata,
  input wire logic        out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed or vanished while stalled");

  a_data_needs_gate: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[17] && !out_tdata[16]))
    else $error("speaker data bit set without the timer gate");

  a_mute_silent: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[20] |-> !out_tdata[17])
    else $error("speaker data bit set while muted");

  a_load_sounds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[17:16] == 2'b11 && !out_tdata[20])
    else $error("divisor loaded without both speaker bits or while muted");

endmodule

bind tone_note_sequencer tns_checker u_tns_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
`default_nettype wire
